[hdl/odc_pkg.sv]
// ----------------------------------------------------------------------------
// odc_pkg
// Shared types, constants and fixed-point helpers of the odometry combiner.
// ----------------------------------------------------------------------------
package odc_pkg;

  localparam int AccW = 66;   // accumulator, holds a Q32.32 cross difference
  localparam int OpAW = 36;   // multiplier operand A, wide enough for t
  localparam int OpBW = 32;   // multiplier operand B
  localparam int ProdW = OpAW + OpBW;
  localparam int TW = 36;     // t = 2 u x v
  localparam int SW = 40;     // rotated lever arm before saturation
  localparam int CW = 48;     // rate x lever, rounded

  localparam logic signed [31:0] LeverXReset = 32'sd13107;
  localparam logic signed [31:0] LeverYReset = 32'sd0;
  localparam logic signed [31:0] LeverZReset = -32'sd8192;
  localparam logic signed [15:0] QOne = 16'sd16384;
  localparam logic signed [15:0] YawC = 16'sd11585;

  typedef enum logic [1:0] {
    OpImu      = 2'd0,
    OpDvl      = 2'd1,
    OpBaro     = 2'd2,
    OpRefReset = 2'd3
  } op_e;

  localparam logic [1:0] CfgLeverX = 2'd0;
  localparam logic [1:0] CfgLeverY = 2'd1;
  localparam logic [1:0] CfgLeverZ = 2'd2;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic neg;
  } mac_ctrl_t;

  // Sign of term j in component i of the Hamilton product a * b.
  function automatic logic qneg(input logic [1:0] comp, input logic [1:0] term);
    logic r;
    r = 1'b0;
    unique case (comp)
      2'd0: r = (term != 2'd0);
      2'd1: r = (term == 2'd3);
      2'd2: r = (term == 2'd1);
      2'd3: r = (term == 2'd2);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] x);
    logic signed [15:0] r;
    if (x > $signed(AccW'(32767))) r = 16'sh7fff;
    else if (x < -$signed(AccW'(32768))) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [31:0] r;
    if (x > $signed(AccW'(64'h7fff_ffff))) r = 32'sh7fff_ffff;
    else if (x < -$signed(AccW'(64'h8000_0000))) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[hdl/odc_if.sv]
// ----------------------------------------------------------------------------
// odc_if
// Stream and configuration channels of the odometry combiner.
// ----------------------------------------------------------------------------
interface odc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] first_vec_x;
  logic signed [31:0] first_vec_y;
  logic signed [31:0] first_vec_z;
  logic signed [31:0] second_vec_x;
  logic signed [31:0] second_vec_y;
  logic signed [31:0] second_vec_z;

  modport source (output valid, op, quat_w, quat_x, quat_y, quat_z, first_vec_x,
                  first_vec_y, first_vec_z, second_vec_x, second_vec_y, second_vec_z,
                  input ready);
  modport sink (input valid, op, quat_w, quat_x, quat_y, quat_z, first_vec_x,
                first_vec_y, first_vec_z, second_vec_x, second_vec_y, second_vec_z,
                output ready);
endinterface

interface odc_out_if;
  logic               valid;
  logic               ready;
  logic               last;
  logic signed [15:0] orient_w;
  logic signed [15:0] orient_x;
  logic signed [15:0] orient_y;
  logic signed [15:0] orient_z;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source (output valid, last, orient_w, orient_x, orient_y, orient_z,
                  vec_x, vec_y, vec_z, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, last, orient_w, orient_x, orient_y, orient_z,
                vec_x, vec_y, vec_z, rate_x, rate_y, rate_z, output ready);
endinterface

interface odc_cfg_if;
  logic               valid;
  logic               ready;
  logic [1:0]         index;
  logic signed [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/odc_mac.sv]
// ----------------------------------------------------------------------------
// odc_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module odc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  odc_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [odc_pkg::OpAW-1:0]     a_i,
  input  logic signed [odc_pkg::OpBW-1:0]     b_i,
  output logic signed [odc_pkg::AccW-1:0]     acc_o
);

  logic signed [odc_pkg::ProdW-1:0] prod_q;
  logic signed [odc_pkg::AccW-1:0]  acc_q, acc_d, base, prod_w;
  logic                             mul_seen_q;

  always_comb begin
    base   = ctrl_i.first ? '0 : acc_q;
    prod_w = prod_q[odc_pkg::AccW-1:0];
    acc_d  = ctrl_i.neg ? base - prod_w : base + prod_w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) prod_q <= a_i * b_i;
    if (ctrl_i.acc_en) acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_seen_q <= 1'b0;
    end else begin
      mul_seen_q <= ctrl_i.mul_en;
    end
  end

  assign acc_o = acc_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.mul_en && ctrl_i.acc_en)) else $error("multiply and accumulate overlap");
  a_prod_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.acc_en |-> mul_seen_q) else $error("accumulate without a fresh product");
  a_acc_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.acc_en |=> !ctrl_i.acc_en) else $error("product accumulated twice");
`endif

endmodule

[hdl/imu_dvl_baro_odometry_combiner_unit.sv]
// ----------------------------------------------------------------------------
// imu_dvl_baro_odometry_combiner_unit
// Fuses IMU, DVL and barometer samples into one odometry state.
// ----------------------------------------------------------------------------
// One input item is handled at a time and every product goes through a single
// shared 36x32 multiplier with an accumulator. Each product is a multiply step
// and an accumulate step, and each finished component gets a write step. An
// IMU sample does two quaternion products (32 terms) and a DVL sample a lever
// rotation and a cross product (21 terms); a barometer sample goes straight to
// its result pair. An output stall holds the pair and no new item is taken.
// A reset-reference item gives no result.
module imu_dvl_baro_odometry_combiner_unit (
  input logic        clk_i,
  input logic        rst_ni,
  odc_in_if.sink     in_i,
  odc_out_if.source  out_o,
  odc_cfg_if.sink    cfg_i
);

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StQMul1   = 11'b000_0000_0010,
    StLatch   = 11'b000_0000_0100,
    StQMul2   = 11'b000_0000_1000,
    StRotT    = 11'b000_0001_0000,
    StRotW    = 11'b000_0010_0000,
    StRotU    = 11'b000_0100_0000,
    StCross   = 11'b000_1000_0000,
    StFin     = 11'b001_0000_0000,
    StOutPose = 11'b010_0000_0000,
    StOutTwist = 11'b100_0000_0000
  } state_e;

  localparam logic [1:0] PhMul = 2'd0;
  localparam logic [1:0] PhAcc = 2'd1;
  localparam logic [1:0] PhWb  = 2'd2;

  state_e state_q, next_step;
  logic [1:0] comp_q, term_q, ph_q;
  logic       latched_q;

  logic signed [31:0] lever_q [3];
  logic signed [15:0] cur_q [4];
  logic signed [15:0] ref_q [4];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] refpos_q [3];

  logic signed [15:0] qin_q [4];
  logic signed [15:0] o_q [4];
  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic signed [odc_pkg::TW-1:0] t_q [3];
  logic signed [odc_pkg::SW-1:0] s_q [3];
  logic signed [odc_pkg::CW-1:0] c_q [3];

  logic signed [15:0] conj [4];
  logic signed [15:0] yaw [4];

  odc_pkg::mac_ctrl_t ctrl;
  logic signed [odc_pkg::OpAW-1:0] op_a;
  logic signed [odc_pkg::OpBW-1:0] op_b;
  logic signed [odc_pkg::AccW-1:0] acc, r13, r14, r16;

  logic is_step, in_xfer, out_xfer;
  logic [1:0] last_term, last_comp, c1, c2, qx;

  function automatic logic signed [odc_pkg::OpAW-1:0] ea16(input logic signed [15:0] x);
    return {{(odc_pkg::OpAW-16){x[15]}}, x};
  endfunction
  function automatic logic signed [odc_pkg::OpAW-1:0] ea32(input logic signed [31:0] x);
    return {{(odc_pkg::OpAW-32){x[31]}}, x};
  endfunction
  function automatic logic signed [odc_pkg::OpBW-1:0] eb16(input logic signed [15:0] x);
    return {{(odc_pkg::OpBW-16){x[15]}}, x};
  endfunction
  function automatic logic signed [odc_pkg::AccW-1:0] w32(input logic signed [31:0] x);
    return {{(odc_pkg::AccW-32){x[31]}}, x};
  endfunction
  function automatic logic signed [15:0] negsat(input logic signed [15:0] x);
    return (x == 16'sh8000) ? 16'sh7fff : -x;
  endfunction

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;

  assign is_step = (state_q == StQMul1) || (state_q == StQMul2) || (state_q == StRotT) ||
                   (state_q == StRotW) || (state_q == StRotU) || (state_q == StCross);

  // Index helpers: c1 and c2 step the cross-product index modulo three, qx pairs quaternion terms.
  assign c1 = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
  assign c2 = (comp_q == 2'd0) ? 2'd2 : comp_q - 2'd1;
  assign qx = comp_q ^ term_q;

  always_comb begin
    yaw[0]  = odc_pkg::YawC;
    yaw[1]  = '0;
    yaw[2]  = '0;
    yaw[3]  = -odc_pkg::YawC;
    conj[0] = ref_q[0];
    conj[1] = negsat(ref_q[1]);
    conj[2] = negsat(ref_q[2]);
    conj[3] = negsat(ref_q[3]);
  end

  always_comb begin
    op_a      = '0;
    op_b      = '0;
    ctrl.neg  = 1'b0;
    last_term = 2'd1;
    last_comp = 2'd2;
    next_step = StIdle;
    unique case (state_q)
      StQMul1: begin
        op_a = ea16(qin_q[term_q]);
        op_b = eb16(yaw[qx]);
        ctrl.neg = odc_pkg::qneg(comp_q, term_q);
        last_term = 2'd3;
        last_comp = 2'd3;
        next_step = StLatch;
      end
      StQMul2: begin
        op_a = ea16(o_q[term_q]);
        op_b = eb16(conj[qx]);
        ctrl.neg = odc_pkg::qneg(comp_q, term_q);
        last_term = 2'd3;
        last_comp = 2'd3;
        next_step = StOutPose;
      end
      StRotT: begin
        op_a = (term_q == 2'd0) ? ea16(cur_q[c1 + 2'd1]) : ea16(cur_q[c2 + 2'd1]);
        op_b = (term_q == 2'd0) ? lever_q[c2] : lever_q[c1];
        ctrl.neg = (term_q != 2'd0);
        next_step = StRotW;
      end
      StRotW: begin
        op_a = t_q[comp_q];
        op_b = eb16(cur_q[0]);
        last_term = 2'd0;
        next_step = StRotU;
      end
      StRotU: begin
        op_a = (term_q == 2'd0) ? t_q[c2] : t_q[c1];
        op_b = (term_q == 2'd0) ? eb16(cur_q[c1 + 2'd1]) : eb16(cur_q[c2 + 2'd1]);
        ctrl.neg = (term_q != 2'd0);
        next_step = StCross;
      end
      StCross: begin
        op_a = (term_q == 2'd0) ? ea32(rate_q[c1]) : ea32(rate_q[c2]);
        op_b = (term_q == 2'd0) ? lever_q[c2] : lever_q[c1];
        ctrl.neg = (term_q != 2'd0);
        next_step = StFin;
      end
      default: begin
        op_a = '0;
      end
    endcase
    ctrl.mul_en = is_step && (ph_q == PhMul);
    ctrl.acc_en = is_step && (ph_q == PhAcc);
    ctrl.first  = (term_q == 2'd0);
  end

  odc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .acc_o  (acc)
  );

  // Round half up with a floor shift.
  assign r13 = (acc + odc_pkg::AccW'(14'sd4096)) >>> 13;
  assign r14 = (acc + odc_pkg::AccW'(15'sd8192)) >>> 14;
  assign r16 = (acc + odc_pkg::AccW'(17'sd32768)) >>> 16;

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      comp_q    <= '0;
      term_q    <= '0;
      ph_q      <= PhMul;
      latched_q <= 1'b0;
      lever_q[0] <= odc_pkg::LeverXReset;
      lever_q[1] <= odc_pkg::LeverYReset;
      lever_q[2] <= odc_pkg::LeverZReset;
      for (int i = 0; i < 4; i++) begin
        cur_q[i] <= (i == 0) ? odc_pkg::QOne : '0;
        ref_q[i] <= (i == 0) ? odc_pkg::QOne : '0;
      end
      for (int i = 0; i < 3; i++) begin
        rate_q[i]   <= '0;
        pos_q[i]    <= '0;
        vel_q[i]    <= '0;
        refpos_q[i] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          odc_pkg::CfgLeverX: lever_q[0] <= cfg_i.data;
          odc_pkg::CfgLeverY: lever_q[1] <= cfg_i.data;
          odc_pkg::CfgLeverZ: lever_q[2] <= cfg_i.data;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            unique case (odc_pkg::op_e'(in_i.op))
              odc_pkg::OpImu: begin
                rate_q[0] <= in_i.first_vec_y;
                rate_q[1] <= odc_pkg::sat32(-w32(in_i.first_vec_x));
                rate_q[2] <= in_i.first_vec_z;
                state_q   <= StQMul1;
              end
              odc_pkg::OpDvl: state_q <= StRotT;
              odc_pkg::OpBaro: begin
                pos_q[2] <= odc_pkg::sat32(w32(in_i.first_vec_z) - w32(refpos_q[2]));
                state_q  <= StOutPose;
              end
              odc_pkg::OpRefReset: begin
                for (int i = 0; i < 3; i++) refpos_q[i] <= pos_q[i];
                for (int i = 0; i < 4; i++) ref_q[i] <= cur_q[i];
              end
              default: ;
            endcase
          end
        end
        StQMul1, StQMul2, StRotT, StRotW, StRotU, StCross: begin
          unique case (ph_q)
            PhMul: ph_q <= PhAcc;
            PhAcc: begin
              if (term_q == last_term) begin
                ph_q <= PhWb;
              end else begin
                term_q <= term_q + 2'd1;
                ph_q   <= PhMul;
              end
            end
            default: begin
              if (state_q == StQMul2) cur_q[comp_q] <= odc_pkg::sat16(r14);
              term_q <= '0;
              ph_q   <= PhMul;
              if (comp_q == last_comp) begin
                comp_q  <= '0;
                state_q <= next_step;
              end else begin
                comp_q <= comp_q + 2'd1;
              end
            end
          endcase
        end
        StLatch: begin
          if (!latched_q) begin
            for (int i = 0; i < 4; i++) ref_q[i] <= o_q[i];
            latched_q <= 1'b1;
          end
          state_q <= StQMul2;
        end
        StFin: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= odc_pkg::sat32(((i == 1) ? w32(a_q[i]) : -w32(a_q[i]))
                        - w32(odc_pkg::sat32({{(odc_pkg::AccW-odc_pkg::SW){s_q[i][odc_pkg::SW-1]}},
                                              s_q[i]}))
                        - w32(refpos_q[i]));
            vel_q[i] <= odc_pkg::sat32(((i == 1) ? w32(b_q[i]) : -w32(b_q[i]))
                        - {{(odc_pkg::AccW-odc_pkg::CW){c_q[i][odc_pkg::CW-1]}}, c_q[i]});
          end
          state_q <= StOutPose;
        end
        StOutPose: begin
          if (out_xfer) state_q <= StOutTwist;
        end
        StOutTwist: begin
          if (out_xfer) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      qin_q[0] <= in_i.quat_w;
      qin_q[1] <= in_i.quat_x;
      qin_q[2] <= in_i.quat_y;
      qin_q[3] <= in_i.quat_z;
      a_q[0] <= in_i.first_vec_x;
      a_q[1] <= in_i.first_vec_y;
      a_q[2] <= in_i.first_vec_z;
      b_q[0] <= in_i.second_vec_x;
      b_q[1] <= in_i.second_vec_y;
      b_q[2] <= in_i.second_vec_z;
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= {{(odc_pkg::SW-32){lever_q[i][31]}}, lever_q[i]};
      end
    end
    if (is_step && (ph_q == PhWb)) begin
      if (state_q == StQMul1) o_q[comp_q] <= odc_pkg::sat16(r14);
      if (state_q == StRotT) t_q[comp_q] <= r13[odc_pkg::TW-1:0];
      if ((state_q == StRotW) || (state_q == StRotU)) begin
        s_q[comp_q] <= s_q[comp_q] + r14[odc_pkg::SW-1:0];
      end
      if (state_q == StCross) c_q[comp_q] <= r16[odc_pkg::CW-1:0];
    end
  end

  always_comb begin
    out_o.valid    = (state_q == StOutPose) || (state_q == StOutTwist);
    out_o.last     = (state_q == StOutTwist);
    out_o.orient_w = out_o.last ? '0 : cur_q[0];
    out_o.orient_x = out_o.last ? '0 : cur_q[1];
    out_o.orient_y = out_o.last ? '0 : cur_q[2];
    out_o.orient_z = out_o.last ? '0 : cur_q[3];
    out_o.vec_x    = out_o.last ? vel_q[0] : pos_q[0];
    out_o.vec_y    = out_o.last ? vel_q[1] : pos_q[1];
    out_o.vec_z    = out_o.last ? vel_q[2] : pos_q[2];
    out_o.rate_x   = out_o.last ? rate_q[0] : '0;
    out_o.rate_y   = out_o.last ? rate_q[1] : '0;
    out_o.rate_z   = out_o.last ? rate_q[2] : '0;
  end

`ifndef SYNTHESIS
  a_busy_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("input ready while results pending");
  a_pose_then_twist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !out_o.last) |=> (out_o.valid && out_o.last))
    else $error("pose transfer not followed by twist");
  a_twist_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_o.last) |=> in_i.ready) else $error("twist did not end the item");
  a_refreset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_i.op == odc_pkg::OpRefReset)) |=> (in_i.ready && !out_o.valid))
    else $error("reference reset produced work");
  a_latch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(latched_q)) else $error("reference latch cleared");
`endif

endmodule

[bench/tb_imu_dvl_baro_odometry_combiner_unit.sv]
// ----------------------------------------------------------------------------
// tb_imu_dvl_baro_odometry_combiner_unit
// Self-checking bench for the odometry combiner. A fixed-point model of the
// fusion predicts every pose and twist pair. Directed and random sensor
// samples are sent under several lever-arm settings, with idle gaps on the
// input, stalls on the output and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_imu_dvl_baro_odometry_combiner_unit;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [15:0] quat_t [4];
  typedef logic signed [31:0] vec3_t [3];

  typedef struct {
    odc_pkg::op_e       op;
    logic signed [15:0] q [4];
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
  } sample_t;

  typedef struct {
    logic               last;
    logic signed [15:0] q [4];
    logic signed [31:0] v [3];
    logic signed [31:0] r [3];
  } odom_t;

  function automatic wide_t round_shift(wide_t x, int s);
    return (x + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clip16(wide_t x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic logic signed [31:0] clip32(wide_t x);
    if (x > wide_t'(64'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (x < -wide_t'(64'sh8000_0000)) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  class odom_scoreboard;
    logic signed [31:0] lever [3];
    quat_t  cur_q, ref_q;
    vec3_t  cur_pos, cur_vel, cur_rate, ref_pos;
    bit     ref_set;
    odom_t  pending_odom [$];
    int     failures, checked, accepted;

    function new();
      lever[0] = odc_pkg::LeverXReset;
      lever[1] = odc_pkg::LeverYReset;
      lever[2] = odc_pkg::LeverZReset;
      cur_q = '{odc_pkg::QOne, 0, 0, 0};
      ref_q = '{odc_pkg::QOne, 0, 0, 0};
      cur_pos = '{0, 0, 0};
      cur_vel = '{0, 0, 0};
      cur_rate = '{0, 0, 0};
      ref_pos = '{0, 0, 0};
      ref_set = 0;
      failures = 0;
      checked = 0;
      accepted = 0;
    endfunction

    function void write_lever(logic [1:0] idx, logic signed [31:0] val);
      if (idx <= odc_pkg::CfgLeverZ) lever[idx] = val;
    endfunction

    function quat_t hamilton(quat_t x, quat_t y);
      quat_t r;
      wide_t aw, ax, ay, az, bw, bx, by, bz;
      aw = x[0]; ax = x[1]; ay = x[2]; az = x[3];
      bw = y[0]; bx = y[1]; by = y[2]; bz = y[3];
      r[0] = clip16(round_shift(aw * bw - ax * bx - ay * by - az * bz, 14));
      r[1] = clip16(round_shift(aw * bx + ax * bw + ay * bz - az * by, 14));
      r[2] = clip16(round_shift(aw * by - ax * bz + ay * bw + az * bx, 14));
      r[3] = clip16(round_shift(aw * bz + ax * by - ay * bx + az * bw, 14));
      return r;
    endfunction

    function vec3_t rotate_lever(quat_t q);
      vec3_t r;
      wide_t w, u0, u1, u2, v0, v1, v2, t0, t1, t2;
      w = q[0]; u0 = q[1]; u1 = q[2]; u2 = q[3];
      v0 = lever[0]; v1 = lever[1]; v2 = lever[2];
      t0 = round_shift(u1 * v2 - u2 * v1, 13);
      t1 = round_shift(u2 * v0 - u0 * v2, 13);
      t2 = round_shift(u0 * v1 - u1 * v0, 13);
      r[0] = clip32(v0 + round_shift(w * t0, 14) + round_shift(u1 * t2 - u2 * t1, 14));
      r[1] = clip32(v1 + round_shift(w * t1, 14) + round_shift(u2 * t0 - u0 * t2, 14));
      r[2] = clip32(v2 + round_shift(w * t2, 14) + round_shift(u0 * t1 - u1 * t0, 14));
      return r;
    endfunction

    function void note_input(sample_t s);
      quat_t yaw, o, cj;
      vec3_t lw;
      wide_t w0, w1, w2, l0, l1, l2, c0, c1, c2;
      odom_t pose, twist;
      accepted++;
      case (s.op)
        odc_pkg::OpRefReset: begin
          ref_pos = cur_pos;
          ref_q = cur_q;
          return;
        end
        odc_pkg::OpImu: begin
          yaw = '{odc_pkg::YawC, 0, 0, -odc_pkg::YawC};
          o = hamilton(s.q, yaw);
          if (!ref_set) begin
            ref_q = o;
            ref_set = 1;
          end
          cj[0] = ref_q[0];
          for (int i = 1; i < 4; i++) cj[i] = clip16(-wide_t'(ref_q[i]));
          cur_q = hamilton(o, cj);
          cur_rate[0] = s.a[1];
          cur_rate[1] = clip32(-wide_t'(s.a[0]));
          cur_rate[2] = s.a[2];
        end
        odc_pkg::OpDvl: begin
          lw = rotate_lever(cur_q);
          cur_pos[0] = clip32(-wide_t'(s.a[0]) - lw[0] - ref_pos[0]);
          cur_pos[1] = clip32(wide_t'(s.a[1]) - lw[1] - ref_pos[1]);
          cur_pos[2] = clip32(-wide_t'(s.a[2]) - lw[2] - ref_pos[2]);
          w0 = cur_rate[0]; w1 = cur_rate[1]; w2 = cur_rate[2];
          l0 = lever[0]; l1 = lever[1]; l2 = lever[2];
          c0 = round_shift(w1 * l2 - w2 * l1, 16);
          c1 = round_shift(w2 * l0 - w0 * l2, 16);
          c2 = round_shift(w0 * l1 - w1 * l0, 16);
          cur_vel[0] = clip32(-wide_t'(s.b[0]) - c0);
          cur_vel[1] = clip32(wide_t'(s.b[1]) - c1);
          cur_vel[2] = clip32(-wide_t'(s.b[2]) - c2);
        end
        default: cur_pos[2] = clip32(wide_t'(s.a[2]) - ref_pos[2]);
      endcase
      pose.last = 0;
      pose.q = cur_q;
      pose.v = cur_pos;
      pose.r = '{0, 0, 0};
      twist.last = 1;
      twist.q = '{0, 0, 0, 0};
      twist.v = cur_vel;
      twist.r = cur_rate;
      pending_odom.push_back(pose);
      pending_odom.push_back(twist);
    endfunction

    function void check_result(odom_t got);
      odom_t exp_o;
      checked++;
      if (pending_odom.size() == 0) begin
        $display("%0t: unexpected result, last=%0d", $time, got.last);
        failures++;
        return;
      end
      exp_o = pending_odom.pop_front();
      if (got.last !== exp_o.last) begin
        $display("%0t: last expected %0d actual %0d", $time, exp_o.last, got.last);
        failures++;
      end
      for (int i = 0; i < 4; i++)
        if (got.q[i] !== exp_o.q[i]) begin
          $display("%0t: orient[%0d] expected %0d actual %0d", $time, i, exp_o.q[i], got.q[i]);
          failures++;
        end
      for (int i = 0; i < 3; i++) begin
        if (got.v[i] !== exp_o.v[i]) begin
          $display("%0t: vec[%0d] expected %0d actual %0d", $time, i, exp_o.v[i], got.v[i]);
          failures++;
        end
        if (got.r[i] !== exp_o.r[i]) begin
          $display("%0t: rate[%0d] expected %0d actual %0d", $time, i, exp_o.r[i], got.r[i]);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  odc_in_if  in_if ();
  odc_out_if out_if ();
  odc_cfg_if cfg_if ();

  imu_dvl_baro_odometry_combiner_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  odom_scoreboard sb;
  int  gap_pct, stall_pct, hold_cycles;
  longint cycle_count;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    odom_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.last = out_if.last;
      got.q = '{out_if.orient_w, out_if.orient_x, out_if.orient_y, out_if.orient_z};
      got.v = '{out_if.vec_x, out_if.vec_y, out_if.vec_z};
      got.r = '{out_if.rate_x, out_if.rate_y, out_if.rate_z};
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic sample_t make_sample(odc_pkg::op_e op,
      logic signed [15:0] qw, logic signed [15:0] qx,
      logic signed [15:0] qy, logic signed [15:0] qz,
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
      logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz);
    sample_t s;
    s.op = op;
    s.q = '{qw, qx, qy, qz};
    s.a = '{ax, ay, az};
    s.b = '{bx, by, bz};
    return s;
  endfunction

  function automatic logic signed [31:0] rand_vec();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return $signed(32'($urandom_range(2097152))) - 32'sd1048576;
    if (pick == 6) return 32'sh7fff_ffff;
    if (pick == 7) return 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    real c [4];
    real n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 38) s.op = odc_pkg::OpImu;
    else if (pick < 76) s.op = odc_pkg::OpDvl;
    else if (pick < 92) s.op = odc_pkg::OpBaro;
    else s.op = odc_pkg::OpRefReset;
    if ($urandom_range(9) < 7) begin
      // Mostly unit quaternions, which is what the rotation math assumes.
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        c[i] = $itor($signed($urandom_range(20000))) - 10000.0;
        n += c[i] * c[i];
      end
      if (n < 1.0) n = 1.0;
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) s.q[i] = 16'($rtoi(c[i] * 16384.0 / n));
    end else begin
      for (int i = 0; i < 4; i++) s.q[i] = $urandom;
    end
    for (int i = 0; i < 3; i++) begin
      s.a[i] = rand_vec();
      s.b[i] = rand_vec();
    end
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= s.op;
    in_if.quat_w <= s.q[0];
    in_if.quat_x <= s.q[1];
    in_if.quat_y <= s.q[2];
    in_if.quat_z <= s.q[3];
    in_if.first_vec_x <= s.a[0];
    in_if.first_vec_y <= s.a[1];
    in_if.first_vec_z <= s.a[2];
    in_if.second_vec_x <= s.b[0];
    in_if.second_vec_y <= s.b[1];
    in_if.second_vec_z <= s.b[2];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(s);
  endtask

  // Lets the block finish its last transfer before anything is reconfigured.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_odom.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic signed [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_lever(idx, val);
  endtask

  task automatic set_levers(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    write_reg(odc_pkg::CfgLeverX, x);
    write_reg(odc_pkg::CfgLeverY, y);
    write_reg(odc_pkg::CfgLeverZ, z);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    sample_t dir [$];
    int gaps [4];
    int stalls [4];
    sb = new();
    gaps = '{0, 62, 0, 32};
    stalls = '{0, 0, 62, 32};
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = odc_pkg::OpImu;
    in_if.quat_w = 0;
    in_if.quat_x = 0;
    in_if.quat_y = 0;
    in_if.quat_z = 0;
    in_if.first_vec_x = 0;
    in_if.first_vec_y = 0;
    in_if.first_vec_z = 0;
    in_if.second_vec_x = 0;
    in_if.second_vec_y = 0;
    in_if.second_vec_z = 0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = 0;
    cfg_if.data = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: sensors before the reference latches, the latch itself,
    // saturating negations and products, and the reference reset.
    dir.push_back(make_sample(odc_pkg::OpBaro, 0, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpDvl, 0, 0, 0, 0, 65536, -65536, 32'sh8000_0000,
                              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
    dir.push_back(make_sample(odc_pkg::OpImu, 16384, 0, 0, 0, 32'sh8000_0000, 65536, -1,
                              0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpImu, 11585, 0, 0, 11585, 32'sh7fff_ffff,
                              32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpDvl, 0, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000,
                              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff));
    dir.push_back(make_sample(odc_pkg::OpImu, -32768, -32768, -32768, -32768, 0, 0, 0,
                              0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpImu, 32767, 32767, 32767, 32767, -1, -1, -1,
                              -1, -1, -1));
    dir.push_back(make_sample(odc_pkg::OpDvl, 0, 0, 0, 0, 1000, 2000, 3000, 10, 20, 30));
    dir.push_back(make_sample(odc_pkg::OpRefReset, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpBaro, 0, 0, 0, 0, 0, 0, 32'sh8000_0000, 0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpDvl, 0, 0, 0, 0, 5000, -7000, 9000, 1, 2, 3));
    dir.push_back(make_sample(odc_pkg::OpImu, 8192, 8192, 8192, 8192, 12345, -54321, 777,
                              0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpDvl, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpRefReset, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    dir.push_back(make_sample(odc_pkg::OpImu, 0, 16384, 0, 0, 32'sh7fff_ffff,
                              32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0));
    dir.push_back(make_sample(odc_pkg::OpDvl, 0, 0, 0, 0, -1, -1, -1, 32'sh8000_0000,
                              32'sh8000_0000, 32'sh8000_0000));
    dir.push_back(make_sample(odc_pkg::OpBaro, 0, 0, 0, 0, 0, 0, 123456, 0, 0, 0));
    foreach (dir[i]) send_sample(dir[i]);
    drain();

    // Five lever settings; the first keeps the reset values.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_levers(odc_pkg::LeverXReset, odc_pkg::LeverYReset, odc_pkg::LeverZReset);
        1: set_levers(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        2: set_levers(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        3: set_levers(0, 0, 0);
        default: set_levers($urandom, $urandom, $urandom);
      endcase
      for (int k = 0; k < 4; k++) begin
        gap_pct = gaps[k];
        stall_pct = stalls[k];
        // One long output hold-off so the block backs up into its input.
        if (ph == 0 && k == 0) hold_cycles = 400;
        for (int n = 0; n < 85; n++) send_sample(rand_sample());
      end
      drain();
    end

    $display("Sent %0d sensor samples over five lever settings; checked %0d results.",
             sb.accepted, sb.checked);
    if (sb.failures == 0 && sb.pending_odom.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/odc_pkg.sv
hdl/odc_if.sv
hdl/odc_mac.sv
hdl/imu_dvl_baro_odometry_combiner_unit.sv
bench/tb_imu_dvl_baro_odometry_combiner_unit.sv
